@@ src/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;
  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_W = $clog2(ORDER_SLOTS);

  localparam logic [1:0] ACT_LIMIT  = 2'd0;
  localparam logic [1:0] ACT_MARKET = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  localparam logic [2:0] ST_FILLED    = 3'd0;
  localparam logic [2:0] ST_POSTED    = 3'd1;
  localparam logic [2:0] ST_DISCARDED = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_UNKNOWN   = 3'd5;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // s_tdata: action, id, side, price, quantity (99 bits -> 104)
  localparam int IN_W = 104;
  // m_tdata: aggressor id, maker id, trade price, trade quantity, status (131 -> 136)
  localparam int OUT_W = 136;
endpackage

@@ src/limit_order_book_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority order book matching limit, market and cancel orders.
// ----------------------------------------------------------------------------
// Each order transaction is handled alone. A sequencer walks the slot store
// one slot per cycle with a single compare unit; each sweep issues a read for
// every slot and then makes the last compare in S_LAST. Every result costs one
// sweep, the S_ACT state to act on the chosen slot and a stay in the output
// register: a limit or market order runs one sweep per fill plus one to find
// the final best or free slot, and a cancel runs one sweep. After its done
// report is accepted the block goes back to idle before the next order can
// be taken. Each result is held in the output register until it is taken,
// stalling the sequencer meanwhile.
// The slot store is a memory read one address a cycle; valid bits live in
// flip-flops cleared by reset, so no clearing pass is run.
module limit_order_book_matcher_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // lowest first: action[1:0], id[31:0], side, price[31:0], quantity[31:0]
  input  logic [lobm_pkg::IN_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // lowest first: aggressor id, maker id, trade price, trade quantity, status[2:0]
  output logic [lobm_pkg::OUT_W-1:0] m_tdata,
  output logic m_tuser,   // kind
  output logic m_tlast
);
  import lobm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Slot store (memory) and valid flags.
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic        mem_side  [ORDER_SLOTS];
  logic [31:0] mem_price [ORDER_SLOTS];
  logic [31:0] mem_qty   [ORDER_SLOTS];
  logic [31:0] mem_id    [ORDER_SLOTS];
  logic [31:0] mem_arr   [ORDER_SLOTS];

  logic [2:0]  state;
  logic [1:0]  action;
  logic [31:0] aggr_id, price, remaining, arrival_counter;
  logic        side;
  logic [SLOT_W:0] scan_idx;
  logic [SLOT_W-1:0] rd_idx, cmp_idx;
  logic        rd_vld;
  logic        rd_side;
  logic [31:0] rd_price, rd_qty, rd_id, rd_arr;
  logic        best_found, free_found;
  logic [SLOT_W-1:0] best_idx, free_idx;
  logic [31:0] best_price, best_qty, best_id, best_arr;
  logic [SLOT_W:0] fills;
  logic        done_pending;

  logic        out_valid, out_kind, out_last;
  logic [31:0] out_rest, out_px, out_qty;
  logic [2:0]  out_status;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'd0, out_status, out_qty, out_px, out_rest, aggr_id};

  // Candidate checks on the registered read data.
  logic rs;
  logic cand_ok, cand_ahead, cancel_hit;
  always_comb begin
    rs = ~side;
    cand_ok = rd_vld && (rd_side == rs);
    if (action == ACT_LIMIT) begin
      if (rs && rd_price > price) cand_ok = 1'b0;
      if (!rs && rd_price < price) cand_ok = 1'b0;
    end
    if (!best_found) cand_ahead = 1'b1;
    else if (rd_price != best_price) cand_ahead = rs ? (rd_price < best_price)
                                                     : (rd_price > best_price);
    else cand_ahead = rd_arr < best_arr;
    cancel_hit = rd_vld && (rd_id == aggr_id) &&
                 (!best_found || rd_arr > best_arr);
  end

  logic [31:0] fill;
  assign fill = (remaining < best_qty) ? remaining : best_qty;

  // The next result is a fill when a crossing order is still open and the
  // sweep limit has not been reached.
  logic take_fill;
  assign take_fill = (action == ACT_LIMIT || action == ACT_MARKET) &&
                     (remaining != '0) && best_found &&
                     (fills != (SLOT_W+1)'(ORDER_SLOTS));

  always_ff @(posedge clk) begin
    // Registered memory read, one address per cycle; cmp_idx tags the data.
    rd_vld   <= slot_valid[rd_idx] && (state == S_SCAN);
    rd_side  <= mem_side[rd_idx];
    rd_price <= mem_price[rd_idx];
    rd_qty   <= mem_qty[rd_idx];
    rd_id    <= mem_id[rd_idx];
    rd_arr   <= mem_arr[rd_idx];
    cmp_idx  <= rd_idx;
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      arrival_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            action    <= s_tdata[1:0];
            aggr_id   <= s_tdata[33:2];
            side      <= s_tdata[34];
            price     <= s_tdata[66:35];
            remaining <= s_tdata[98:67];
            fills <= '0;
            scan_idx <= '0;
            rd_idx <= '0;
            best_found <= 1'b0;
            free_found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue the next read; the compare below sees an earlier one.
          if (scan_idx != (SLOT_W+1)'(ORDER_SLOTS)) begin
            rd_idx <= scan_idx[SLOT_W-1:0];
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_idx != '0) begin
            if (!slot_valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= cmp_idx;
            end
            if (action == ACT_CANCEL ? cancel_hit : (cand_ok && cand_ahead)) begin
              best_found <= 1'b1;
              best_idx <= cmp_idx;
              best_price <= rd_price;
              best_qty <= rd_qty;
              best_id <= rd_id;
              best_arr <= rd_arr;
            end
          end
          if (scan_idx == (SLOT_W+1)'(ORDER_SLOTS)) state <= S_LAST;
        end
        S_LAST: begin
          if (!slot_valid[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx <= cmp_idx;
          end
          if (action == ACT_CANCEL ? cancel_hit : (cand_ok && cand_ahead)) begin
            best_found <= 1'b1;
            best_idx <= cmp_idx;
            best_price <= rd_price;
            best_qty <= rd_qty;
            best_id <= rd_id;
            best_arr <= rd_arr;
          end
          state <= S_ACT;
        end
        S_ACT: begin
          out_valid <= 1'b1;
          out_kind <= take_fill ? KIND_FILL : KIND_DONE;
          out_last <= !take_fill;
          done_pending <= !take_fill;
          out_rest <= take_fill ? best_id : 32'd0;
          out_px <= take_fill ? best_price : 32'd0;
          if (action == ACT_CANCEL) begin
            out_qty <= best_found ? best_qty : 32'd0;
            out_status <= best_found ? ST_CANCELLED : ST_UNKNOWN;
            if (best_found) slot_valid[best_idx] <= 1'b0;
          end else if (action != ACT_LIMIT && action != ACT_MARKET) begin
            out_qty <= '0;
            out_status <= ST_UNKNOWN;
          end else if (take_fill) begin
            // One fill against the best resting order.
            out_qty <= fill;
            out_status <= ST_FILLED;
            remaining <= remaining - fill;
            mem_qty[best_idx] <= best_qty - fill;
            if (best_qty == fill) slot_valid[best_idx] <= 1'b0;
            fills <= fills + 1'b1;
          end else if (remaining == '0) begin
            out_qty <= '0;
            out_status <= ST_FILLED;
          end else if (action == ACT_MARKET) begin
            out_qty <= remaining;
            out_status <= ST_DISCARDED;
          end else if (!free_found) begin
            out_qty <= remaining;
            out_status <= ST_REJECTED;
          end else begin
            slot_valid[free_idx] <= 1'b1;
            mem_side[free_idx] <= side;
            mem_price[free_idx] <= price;
            mem_qty[free_idx] <= remaining;
            mem_id[free_idx] <= aggr_id;
            mem_arr[free_idx] <= arrival_counter;
            arrival_counter <= arrival_counter + 1'b1;
            out_qty <= remaining;
            out_status <= ST_POSTED;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (done_pending) state <= S_IDLE;
            else begin
              scan_idx <= '0;
              rd_idx <= '0;
              best_found <= 1'b0;
              free_found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/lobm_checker.sv @@
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks of the order book matcher.
// ----------------------------------------------------------------------------
module lobm_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic m_tuser,
  input logic m_tlast,
  input logic [lobm_pkg::OUT_W-1:0] m_tdata
);
  import lobm_pkg::*;

  // A result is pending only while no new order can be taken.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready while result pending");
  // The done report carries last; fills do not.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == KIND_DONE))) else $error("last mismatch");
  // Fills report status zero.
  a_fst: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_FILL) |-> m_tdata[130:128] == ST_FILLED)
    else $error("fill status");
  // Result stays while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result dropped");
endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (.*);

@@ bench/tb_limit_order_book_matcher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_unit
// Self-checking bench for the order book matcher: a behavioral book inside
// the scoreboard predicts the fills and done reports of every order, and the
// results from the block are compared with them field by field, in order.
// ----------------------------------------------------------------------------
import lobm_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [31:0] trade_qty;
  logic [31:0] trade_px;
  logic [31:0] maker_id;
  logic [31:0] aggressor_id;
} report_t;

typedef struct {
  logic        kind;
  report_t     rep;
  logic        last;
} book_result_t;

// Scoreboard that keeps a model of the order book and the queue of results
// that the orders seen so far must still produce.
class book_scoreboard;
  bit          live[ORDER_SLOTS];
  bit          sd[ORDER_SLOTS];
  bit [31:0]   px[ORDER_SLOTS];
  bit [31:0]   qty[ORDER_SLOTS];
  bit [31:0]   oid[ORDER_SLOTS];
  bit [31:0]   arr[ORDER_SLOTS];
  bit [31:0]   arrival_count;
  book_result_t pending[$];
  int          errors;

  function void push_result(logic kind, bit [31:0] aggr, bit [31:0] rest,
                            bit [31:0] p, bit [31:0] q, logic [2:0] st);
    book_result_t r;
    r.kind = kind;
    r.rep.aggressor_id = aggr;
    r.rep.maker_id = rest;
    r.rep.trade_px = p;
    r.rep.trade_qty = q;
    r.rep.status = st;
    r.last = kind;
    pending.insert(pending.size(), r);
  endfunction

  function bit outranks(int a, int b, bit rs);
    if (px[a] != px[b]) return rs ? (px[a] < px[b]) : (px[a] > px[b]);
    if (arr[a] != arr[b]) return arr[a] < arr[b];
    return a < b;
  endfunction

  function int best_resting(bit rs, bit gated, bit [31:0] lim);
    int best;
    best = -1;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (!live[i] || sd[i] != rs) continue;
      if (gated && rs && px[i] > lim) continue;
      if (gated && !rs && px[i] < lim) continue;
      if (best < 0 || outranks(i, best, rs)) best = i;
    end
    return best;
  endfunction

  function int live_count();
    int n;
    n = 0;
    foreach (live[i]) n += live[i];
    return n;
  endfunction

  // Applies one accepted order to the book and queues its expected results.
  function void note_order(logic [1:0] act, bit [31:0] id, bit s, bit [31:0] p,
                           bit [31:0] q);
    int hit, b, fr, guard;
    bit [31:0] rem, f;
    if (act == ACT_CANCEL) begin
      hit = -1;
      for (int i = 0; i < ORDER_SLOTS; i++)
        if (live[i] && oid[i] == id && (hit < 0 || arr[i] > arr[hit])) hit = i;
      if (hit < 0) push_result(KIND_DONE, id, 0, 0, 0, ST_UNKNOWN);
      else begin
        live[hit] = 0;
        push_result(KIND_DONE, id, 0, 0, qty[hit], ST_CANCELLED);
      end
      return;
    end
    if (act != ACT_LIMIT && act != ACT_MARKET) begin
      push_result(KIND_DONE, id, 0, 0, 0, ST_UNKNOWN);
      return;
    end
    rem = q;
    guard = 0;
    while (rem > 0 && guard < ORDER_SLOTS) begin
      b = best_resting(!s, act == ACT_LIMIT, p);
      if (b < 0) break;
      f = (rem < qty[b]) ? rem : qty[b];
      rem -= f;
      qty[b] -= f;
      push_result(KIND_FILL, id, oid[b], px[b], f, ST_FILLED);
      if (qty[b] == 0) live[b] = 0;
      guard++;
    end
    if (rem == 0) push_result(KIND_DONE, id, 0, 0, 0, ST_FILLED);
    else if (act == ACT_MARKET) push_result(KIND_DONE, id, 0, 0, rem, ST_DISCARDED);
    else begin
      fr = -1;
      for (int i = 0; i < ORDER_SLOTS; i++)
        if (!live[i]) begin
          fr = i;
          break;
        end
      if (fr < 0) push_result(KIND_DONE, id, 0, 0, rem, ST_REJECTED);
      else begin
        live[fr] = 1;
        sd[fr] = s;
        px[fr] = p;
        qty[fr] = rem;
        oid[fr] = id;
        arr[fr] = arrival_count;
        arrival_count++;
        push_result(KIND_DONE, id, 0, 0, rem, ST_POSTED);
      end
    end
  endfunction

  // Compares one result from the block with the oldest expected result.
  function void check_report(logic kind, report_t rep, logic last);
    book_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transaction, aggressor_id %0h", rep.aggressor_id);
      errors++;
      return;
    end
    e = pending[0];
    pending.delete(0);
    if (kind !== e.kind) begin
      $error("kind: expected %0d, got %0d", e.kind, kind); errors++;
    end
    if (rep.aggressor_id !== e.rep.aggressor_id) begin
      $error("aggressor_id: expected %0h, got %0h", e.rep.aggressor_id,
             rep.aggressor_id); errors++;
    end
    if (rep.maker_id !== e.rep.maker_id) begin
      $error("maker_id: expected %0h, got %0h", e.rep.maker_id,
             rep.maker_id); errors++;
    end
    if (rep.trade_px !== e.rep.trade_px) begin
      $error("trade_px: expected %0h, got %0h", e.rep.trade_px,
             rep.trade_px); errors++;
    end
    if (rep.trade_qty !== e.rep.trade_qty) begin
      $error("trade_qty: expected %0h, got %0h", e.rep.trade_qty,
             rep.trade_qty); errors++;
    end
    if (rep.status !== e.rep.status) begin
      $error("status: expected %0d, got %0d", e.rep.status, rep.status); errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, last); errors++;
    end
  endfunction
endclass

module tb_limit_order_book_matcher_unit;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  book_scoreboard book = new();

  // Receiver controls: a long hold-off is counted in the receiver's process.
  bit quiet_tail = 0;
  int hold_off_cycles = 0;

  // A small set of recent ids keeps cancels hitting live orders.
  bit [31:0] recent_ids[$];

  always #6 clk = ~clk;

  limit_order_book_matcher_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // Results are checked at the rising edge where the transaction completes.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready)
      book.check_report(m_tuser, report_t'(m_tdata[130:0]), m_tlast);

  // Receiver: random stall bursts, none in the tail.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offers one order and waits for its acceptance; the order is noted in the
  // book at the accepting edge, so its results are predicted in input order.
  // Valid stays high into the next order unless the sender idles.
  task automatic send_order(logic [1:0] act, bit [31:0] id, bit s, bit [31:0] p,
                            bit [31:0] q);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tdata <= {5'b0, q, p, s, id, act};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_order(act, id, s, p, q);
    if (recent_ids.size() > 12) recent_ids.delete(0);
    recent_ids.insert(recent_ids.size(), id);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (book.pending.size() != 0) @(negedge clk);
  endtask

  function automatic bit [31:0] pick_id();
    if (recent_ids.size() > 0 && $urandom_range(0, 2) != 0)
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    return $urandom();
  endfunction

  // Random order, mostly well-formed and near a mid price, so that books cross often.
  task automatic random_order();
    int r;
    bit [31:0] p, q;
    logic [1:0] act;
    r = $urandom_range(0, 99);
    p = 1000 + $urandom_range(0, 12);
    q = $urandom_range(1, 60);
    if (r < 55) act = ACT_LIMIT;
    else if (r < 70) act = ACT_MARKET;
    else if (r < 88) act = ACT_CANCEL;
    else begin
      // Noise: wide fields, zero sizes and the undefined action.
      act = 2'($urandom_range(0, 3));
      p = $urandom();
      q = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
    end
    send_order(act, (act == ACT_CANCEL) ? pick_id() : $urandom(),
               $urandom_range(0, 1), p, q);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed orders: crossing, price-time priority, duplicate ids, zero
    // size, market sweep and discard, cancels and the undefined action.
    send_order(ACT_LIMIT, 32'h11, 1'b1, 32'd100, 32'd10);
    send_order(ACT_LIMIT, 32'h12, 1'b1, 32'd100, 32'd5);
    send_order(ACT_LIMIT, 32'h13, 1'b1, 32'd99, 32'd7);
    send_order(ACT_LIMIT, 32'h14, 1'b0, 32'd100, 32'd12);
    send_order(ACT_LIMIT, 32'h15, 1'b0, 32'd98, 32'd3);
    send_order(ACT_MARKET, 32'h16, 1'b0, 32'd0, 32'd100);
    send_order(ACT_MARKET, 32'h17, 1'b1, 32'hFFFF_FFFF, 32'd2);
    send_order(ACT_LIMIT, 32'h18, 1'b0, 32'd0, 32'd0);
    send_order(ACT_MARKET, 32'h19, 1'b1, 32'd0, 32'd0);
    send_order(ACT_LIMIT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(ACT_LIMIT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd4);
    send_order(ACT_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
    send_order(ACT_CANCEL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(ACT_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0);
    send_order(2'd3, 32'h0, 1'b1, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_order(ACT_LIMIT, 32'h0, 1'b0, 32'h0, 32'd1);
    send_order(ACT_LIMIT, 32'h1A, 1'b1, 32'h0, 32'd3);
    send_order(ACT_CANCEL, 32'h0, 1'b0, 32'd0, 32'd0);

    // Fill the store with resting buys, then one more is rejected full, and
    // a single sell sweeps all of them for the largest result count.
    while (book.live_count() < ORDER_SLOTS)
      send_order(ACT_LIMIT, $urandom(), 1'b0, 32'd500 + $urandom_range(0, 3),
                 32'd1);
    send_order(ACT_LIMIT, 32'h1B, 1'b0, 32'd1, 32'd9);
    // The sender pauses here until every result has arrived.
    wait_drained();
    send_order(ACT_MARKET, 32'h1C, 1'b1, 32'd0, 32'd1000);

    // Long receiver hold-off while orders keep coming, to back up the block.
    hold_off_cycles = 400;
    repeat (6) random_order();

    repeat (140) random_order();
    quiet_tail = 1;
    repeat (20) random_order();

    wait_drained();
    repeat (200) @(negedge clk);
    if (book.errors == 0 && book.pending.size() == 0)
      $display("tb_limit_order_book_matcher_unit passed");
    else
      $display("tb_limit_order_book_matcher_unit failed");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(12 * 3_000_000);
    $display("tb_limit_order_book_matcher_unit failed");
    $finish;
  end
endmodule
